>>> rtl/core/rc5pwd_pkg.sv
`default_nettype none

package rc5pwd_pkg;

    localparam int DATA_W  = 16;
    localparam int FRAME_W = 14;
    localparam int PHASE_W = 5;
    localparam int INDEX_W = 4;
    localparam int IDX_W   = 2;

    localparam logic [INDEX_W-1:0] FRAME_TOP_BIT = 4'd13;
    localparam logic [INDEX_W-1:0] FIRST_DATA_BIT = 4'd12;

    localparam logic [DATA_W-1:0] MAX_BIT_RST  = 16'd1900;
    localparam logic [DATA_W-1:0] MIN_HALF_RST = 16'd700;
    localparam logic [DATA_W-1:0] MAX_HALF_RST = 16'd1000;

    localparam logic [IDX_W-1:0] REG_MAX_BIT  = 2'd0;
    localparam logic [IDX_W-1:0] REG_MIN_HALF = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX_HALF = 2'd2;

    localparam logic MODE_EDGE    = 1'b0;
    localparam logic MODE_TIMEOUT = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_WIDTH = 2'd1;
    localparam logic [1:0] ST_START = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] max_bit_us;
        logic [DATA_W-1:0] min_half_us;
        logic [DATA_W-1:0] max_half_us;
    } cfg_t;

    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] pulse_width_us;
        logic              falling_edge;
    } event_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               toggle;
        logic [4:0]         address;
        logic [5:0]         command;
        logic [FRAME_W-1:0] raw_frame;
        logic [DATA_W-1:0]  frames_seen;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/rc5_pulse_width_decoder.sv
// RC5 infrared frame decoder driven by edge-timing events.
// Input channel (in_valid/in_stall): one word per edge event with mode
// (0 edge, 1 frame timeout), pulse_width_us and falling_edge.
// Output channel (out_valid/out_stall): one word per finished frame or
// per width/start-bit error: status, toggle, address, command, raw_frame,
// frames_seen. Most events produce no output word.
// Config port: cfg_write with cfg_index 0 max_bit_us, 1 min_half_us,
// 2 max_half_us; write only while the decoder is idle.
// Flow: an accepted event is held in the input register, then the
// decode logic updates the frame state and loads the result register.
// A result word is presented from the result register; while out_stall
// holds no waiting result word, the pipe accepts one event every cycle.
// While out_stall holds a waiting result word, the event in the input
// register waits there and in_stall rises, whether or not that event
// produces a word; it is decoded in the cycle the result slot drains.
// Reset: decoder idle (waiting for a start edge), frame count zero,
// registers at 1900/700/1000 us, both channels empty.
`default_nettype none

module rc5_pulse_width_decoder (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [rc5pwd_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [rc5pwd_pkg::DATA_W-1:0]    cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             mode,
    input  wire logic [rc5pwd_pkg::DATA_W-1:0]    pulse_width_us,
    input  wire logic                             falling_edge,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [1:0]                            status,
    output logic                                  toggle,
    output logic [4:0]                            address,
    output logic [5:0]                            command,
    output logic [rc5pwd_pkg::FRAME_W-1:0]        raw_frame,
    output logic [rc5pwd_pkg::DATA_W-1:0]         frames_seen
);

    rc5pwd_pkg::cfg_t    cfg;
    rc5pwd_pkg::event_t  evt_reg;
    rc5pwd_pkg::result_t res;
    rc5pwd_pkg::result_t res_reg;

    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic emit;
    logic out_free;
    logic fire;
    logic accept;

    rc5pwd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // result slot free now or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;

    rc5pwd_dec u_dec (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .evt    (evt_reg),
        .cfg    (cfg),
        .emit   (emit),
        .result (res)
    );

    assign fire     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire && emit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            evt_reg.mode           <= mode;
            evt_reg.pulse_width_us <= pulse_width_us;
            evt_reg.falling_edge   <= falling_edge;
        end
        if (fire && emit)
            res_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign status      = res_reg.status;
    assign toggle      = res_reg.toggle;
    assign address     = res_reg.address;
    assign command     = res_reg.command;
    assign raw_frame   = res_reg.raw_frame;
    assign frames_seen = res_reg.frames_seen;

endmodule

`default_nettype wire

>>> rtl/core/rc5pwd_cfg.sv
`default_nettype none

module rc5pwd_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [rc5pwd_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [rc5pwd_pkg::DATA_W-1:0]    cfg_data,
    output rc5pwd_pkg::cfg_t                      cfg
);

    rc5pwd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_bit_us  <= rc5pwd_pkg::MAX_BIT_RST;
            cfg_reg.min_half_us <= rc5pwd_pkg::MIN_HALF_RST;
            cfg_reg.max_half_us <= rc5pwd_pkg::MAX_HALF_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rc5pwd_pkg::REG_MAX_BIT:  cfg_reg.max_bit_us  <= cfg_data;
                rc5pwd_pkg::REG_MIN_HALF: cfg_reg.min_half_us <= cfg_data;
                rc5pwd_pkg::REG_MAX_HALF: cfg_reg.max_half_us <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/core/rc5pwd_dec.sv
`default_nettype none

module rc5pwd_dec (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  rc5pwd_pkg::event_t        evt,
    input  rc5pwd_pkg::cfg_t          cfg,
    output logic                      emit,
    output rc5pwd_pkg::result_t       result
);

    logic [rc5pwd_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [rc5pwd_pkg::INDEX_W-1:0] index_reg, index_next;
    logic [rc5pwd_pkg::FRAME_W-1:0] bits_reg, bits_next;
    logic [rc5pwd_pkg::DATA_W-1:0]  count_reg, count_next;

    logic [rc5pwd_pkg::PHASE_W-1:0] ph_mid;
    logic [rc5pwd_pkg::FRAME_W-1:0] bit_mask;
    logic [rc5pwd_pkg::FRAME_W-1:0] sampled;
    logic                           width_bad;
    logic                           long_gap;

    assign bit_mask  = rc5pwd_pkg::FRAME_W'(1) << index_reg;
    assign width_bad = (evt.pulse_width_us > cfg.max_bit_us) ||
                       (evt.pulse_width_us < cfg.min_half_us);
    assign long_gap  = evt.pulse_width_us > cfg.max_half_us;
    assign ph_mid    = long_gap ? phase_reg + 5'd1 : phase_reg;
    assign sampled   = evt.falling_edge ? (bits_reg | bit_mask) : bits_reg;

    always_comb
    begin
        phase_next = phase_reg;
        index_next = index_reg;
        bits_next  = bits_reg;
        count_next = count_reg;
        emit       = 1'b0;
        result     = '0;
        result.frames_seen = count_reg;

        if (!fire)
        begin
        end
        else if (evt.mode == rc5pwd_pkg::MODE_TIMEOUT)
        begin
            phase_next = '0;
            index_next = rc5pwd_pkg::FRAME_TOP_BIT;
        end
        else if (phase_reg == '0)
        begin
            phase_next = '0;
            index_next = rc5pwd_pkg::FRAME_TOP_BIT;
            if (evt.falling_edge)
            begin
                phase_next = 5'd1;
                bits_next  = '0;
            end
        end
        else if (width_bad)
        begin
            phase_next    = '0;
            index_next    = rc5pwd_pkg::FRAME_TOP_BIT;
            emit          = 1'b1;
            result.status = rc5pwd_pkg::ST_WIDTH;
        end
        else if (phase_reg == 5'd1 || phase_reg == 5'd2)
        begin
            if (long_gap)
            begin
                phase_next    = '0;
                index_next    = rc5pwd_pkg::FRAME_TOP_BIT;
                emit          = 1'b1;
                result.status = rc5pwd_pkg::ST_START;
            end
            else
            begin
                bits_next  = bits_reg | bit_mask;
                index_next = index_reg - 4'd1;
                phase_next = phase_reg + 5'd1;
            end
        end
        else if (index_reg >= rc5pwd_pkg::FIRST_DATA_BIT)
        begin
        end
        else if (!ph_mid[0])
        begin
            // mid-bit edge
            bits_next = sampled;
            if (index_reg == '0)
            begin
                phase_next         = '0;
                index_next         = rc5pwd_pkg::FRAME_TOP_BIT;
                count_next         = count_reg + 16'd1;
                emit               = 1'b1;
                result.status      = rc5pwd_pkg::ST_DONE;
                result.toggle      = sampled[11];
                result.address     = sampled[10:6];
                result.command     = sampled[5:0];
                result.raw_frame   = sampled;
                result.frames_seen = count_reg + 16'd1;
            end
            else
            begin
                index_next = index_reg - 4'd1;
                phase_next = ph_mid + 5'd1;
            end
        end
        else
        begin
            phase_next = ph_mid + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            index_reg <= rc5pwd_pkg::FRAME_TOP_BIT;
            bits_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            bits_reg  <= bits_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_done_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && result.status == rc5pwd_pkg::ST_DONE) |=>
            (count_reg == $past(count_reg) + 16'd1))
        else $error("frame count did not advance on a finished frame");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && result.status != rc5pwd_pkg::ST_DONE) |->
            (result.raw_frame == '0 && result.frames_seen == count_reg))
        else $error("error word carries frame data");

    a_timeout_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && evt.mode == rc5pwd_pkg::MODE_TIMEOUT) |=>
            (phase_reg == '0 && index_reg == rc5pwd_pkg::FRAME_TOP_BIT))
        else $error("timeout did not return decoder to idle");

    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == '0) |-> !emit)
        else $error("word produced while waiting for a frame");
`endif

endmodule

`default_nettype wire
